@@ rtl/core/scrw_pkg.sv @@
package scrw_pkg;

    // Width of the capacity, window and frame count fields.
    localparam int CNT_W = 7;

    // Width of the numerator fed to the start-offset remainder unit.
    localparam int NUM_W = CNT_W + 1;

    // Number of remainder steps, one numerator bit per step.
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W = $clog2(DIV_STEPS);

    // Largest window that one extraction returns.
    localparam logic [CNT_W-1:0] WINDOW_MAX = 7'd64;

    // Capacity after reset.
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    // Request action codes.
    localparam logic ACT_RECORD  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    // Register map: one 32-bit register per word.
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_LSB = 2;
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_EMIT
    } scrw_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic record;
        logic extract_load;
        logic div_step;
        logic issue;
    } scrw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic full;
        logic div_last;
        logic emit_last;
        logic can_issue;
    } scrw_status_t;

endpackage

@@ rtl/core/scrw_if.sv @@
// Request channel: one record or extract request per transfer.
interface scrw_in_if import scrw_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic [CNT_W-1:0]              window_frames;

    modport source (
        output valid, action, left_sample, right_sample, window_frames,
        input  ready
    );
    modport sink (
        input  valid, action, left_sample, right_sample, window_frames,
        output ready
    );
endinterface

// Result channel: one stereo frame per transfer.
interface scrw_out_if import scrw_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [CNT_W-1:0]              frame_count;
    logic                          last;

    modport source (
        output valid, left_out, right_out, frame_count, last,
        input  ready
    );
    modport sink (
        input  valid, left_out, right_out, frame_count, last,
        output ready
    );
endinterface

@@ rtl/core/scrw_ram.sv @@
// Simple dual-port RAM with one write port and a registered read port.
module scrw_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/scrw_ctrl.sv @@
// Sequencer: takes one request; an extract runs the start-offset remainder when
// the ring is full, then issues one store read per frame of a non-empty window.
module scrw_ctrl import scrw_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_action,
    output logic         in_ready,
    input  scrw_status_t status,
    output scrw_cmd_t    cmd
);

    scrw_state_t state_reg;
    scrw_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_action == ACT_RECORD)
                    begin
                        cmd.record = 1'b1;
                    end
                    else
                    begin
                        cmd.extract_load = 1'b1;
                        state_next       = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                if (status.count_zero)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.full)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.can_issue)
                begin
                    cmd.issue = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The emit phase starts only after the full set of remainder steps.
    a_div_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && $past(state_reg) == ST_DIV) |-> $past(status.div_last))
        else $error("emit phase entered before the remainder finished");

    // A window that came out empty never issues a store read.
    a_no_empty_issue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !status.count_zero)
        else $error("store read issued for an empty window");

endmodule

@@ rtl/core/scrw_datapath.sv @@
// Ring pointers, window arithmetic, start-offset remainder, the frame store
// and a two-entry result queue.
module scrw_datapath import scrw_pkg::*; #(
    parameter int DEPTH       = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [CNT_W-1:0]              capacity,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    input  logic [CNT_W-1:0]              window_frames,
    input  scrw_cmd_t                     cmd,
    output scrw_status_t                  status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    output logic [CNT_W-1:0]              frame_count,
    output logic                          last
);

    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PAIR_W  = 2 * SAMPLE_BITS;
    localparam int ENTRY_W = PAIR_W + CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CAP = (DEPTH > 127) ? 7'd127 : 7'(DEPTH);

    logic [CNT_W-1:0]   eff_cap;
    logic [CNT_W-1:0]   wptr_reg, wptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [CNT_W-1:0]   pend_count_reg, pend_count_next;
    logic               pend_last_reg, pend_last_next;
    logic [ENTRY_W-1:0] q0_reg, q0_next;
    logic [ENTRY_W-1:0] q1_reg, q1_next;
    logic [1:0]         q_cnt_reg, q_cnt_next;

    logic [CNT_W-1:0]   avail;
    logic [CNT_W-1:0]   win_clip;
    logic [CNT_W-1:0]   win_count;
    logic [NUM_W-1:0]   trial;
    logic [NUM_W-1:0]   trial_sub;
    logic [NUM_W-1:0]   wptr_inc;
    logic [NUM_W-1:0]   pos_inc;
    logic               ram_we;
    logic [PAIR_W-1:0]  ram_rdata;
    logic [ENTRY_W-1:0] push_entry;
    logic               push;
    logic               pop;

    // Capacity in use never exceeds the store depth.
    assign eff_cap = (capacity > DEPTH_CAP) ? DEPTH_CAP : capacity;

    // Window length: request clipped by the frames held and the window limit.
    assign avail     = (fill_reg < eff_cap) ? fill_reg : eff_cap;
    assign win_clip  = (window_frames < avail) ? window_frames : avail;
    assign win_count = (win_clip > WINDOW_MAX) ? WINDOW_MAX : win_clip;

    // One restoring remainder step per cycle.
    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign trial_sub = (trial >= {1'b0, eff_cap}) ? trial - {1'b0, eff_cap} : trial;

    assign wptr_inc = {1'b0, wptr_reg} + NUM_W'(1);
    assign pos_inc  = {1'b0, pos_reg} + NUM_W'(1);
    assign ram_we   = cmd.record && (eff_cap != '0);

    // Result queue handshake.
    assign pop        = (q_cnt_reg != 2'd0) && out_ready;
    assign push       = rd_pend_reg;
    assign push_entry = {ram_rdata, pend_count_reg, pend_last_reg};

    // Status to the controller.
    assign status.count_zero = (count_reg == '0);
    assign status.full       = (fill_reg >= eff_cap);
    assign status.div_last   = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign status.emit_last  = (idx_reg == count_reg - CNT_W'(1));
    assign status.can_issue  = (({1'b0, q_cnt_reg} + {2'b0, rd_pend_reg}) != 3'd2) || pop;

    // Frame store holding each left/right pair side by side.
    scrw_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(wptr_reg)),
        .wdata ({left_sample, right_sample}),
        .re    (cmd.issue),
        .raddr (AW'(pos_reg)),
        .rdata (ram_rdata)
    );

    // Pointer, window and remainder updates.
    always_comb
    begin
        wptr_next       = wptr_reg;
        fill_next       = fill_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        rd_pend_next    = 1'b0;
        pend_count_next = pend_count_reg;
        pend_last_next  = pend_last_reg;

        if (ram_we)
        begin
            wptr_next = (wptr_inc >= {1'b0, eff_cap}) ? '0 : wptr_inc[CNT_W-1:0];
            if (fill_reg < eff_cap)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end

        if (cmd.extract_load)
        begin
            count_next = win_count;
            pos_next   = fill_reg - win_count;
            num_next   = {1'b0, wptr_reg} + {1'b0, eff_cap} - {1'b0, win_count};
            rem_next   = '0;
            step_next  = '0;
            idx_next   = '0;
        end

        if (cmd.div_step)
        begin
            rem_next  = trial_sub[CNT_W-1:0];
            num_next  = num_reg << 1;
            step_next = step_reg + STEP_W'(1);
            if (status.div_last)
            begin
                pos_next = trial_sub[CNT_W-1:0];
            end
        end

        if (cmd.issue)
        begin
            pos_next        = (pos_inc >= {1'b0, eff_cap}) ? '0 : pos_inc[CNT_W-1:0];
            idx_next        = idx_reg + CNT_W'(1);
            rd_pend_next    = 1'b1;
            pend_count_next = count_reg;
            pend_last_next  = status.emit_last;
        end
    end

    // Two-entry result queue, head in q0.
    always_comb
    begin
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        q_cnt_next = q_cnt_reg;
        case ({push, pop})
            2'b10:
            begin
                if (q_cnt_reg == 2'd0)
                begin
                    q0_next = push_entry;
                end
                else
                begin
                    q1_next = push_entry;
                end
                q_cnt_next = q_cnt_reg + 2'd1;
            end
            2'b01:
            begin
                q0_next    = q1_reg;
                q_cnt_next = q_cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (q_cnt_reg == 2'd1)
                begin
                    q0_next = push_entry;
                end
                else
                begin
                    q0_next = q1_reg;
                    q1_next = push_entry;
                end
            end
            default:
            begin
                q_cnt_next = q_cnt_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg    <= '0;
            fill_reg    <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            step_reg    <= '0;
            rd_pend_reg <= 1'b0;
            q_cnt_reg   <= 2'd0;
        end
        else
        begin
            wptr_reg    <= wptr_next;
            fill_reg    <= fill_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            step_reg    <= step_next;
            rd_pend_reg <= rd_pend_next;
            q_cnt_reg   <= q_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        num_reg        <= num_next;
        rem_reg        <= rem_next;
        pend_count_reg <= pend_count_next;
        pend_last_reg  <= pend_last_next;
        q0_reg         <= q0_next;
        q1_reg         <= q1_next;
    end

    // Result channel from the queue head.
    assign out_valid   = (q_cnt_reg != 2'd0);
    assign left_out    = q0_reg[ENTRY_W-1 -: SAMPLE_BITS];
    assign right_out   = q0_reg[CNT_W+1 +: SAMPLE_BITS];
    assign frame_count = q0_reg[1 +: CNT_W];
    assign last        = q0_reg[0];

    // Queued plus in-flight reads never exceed the queue depth.
    a_queue_credit: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, q_cnt_reg} + {2'b0, rd_pend_reg}) <= 3'd2)
        else $error("result queue overrun");

    // Every read address lies inside the ring in use.
    a_read_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (pos_reg < eff_cap))
        else $error("store read outside the ring");

    // The write pointer always addresses a real store entry.
    a_wptr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        int'(wptr_reg) < DEPTH)
        else $error("write pointer beyond the store");

endmodule

@@ rtl/core/stereo_capture_ring_window_top.sv @@
// Stereo capture ring with newest-window readout. A record request writes one
// left/right Q1.23 pair into a ring of "capacity" frames (register 0, reset 64)
// when it is accepted, and nothing at capacity 0. An extract request returns the newest
// min(window_frames, frames held, 64) frames, oldest first, one result per
// frame with the window length and a last flag on the final frame; an empty
// window returns nothing. Extraction loads the window, passes a setup state,
// runs the start-offset remainder (one numerator bit per cycle) once the
// ring has wrapped, and then reads one frame per cycle from the single read port of
// the frame store while the result sink keeps up. A two-entry result queue
// sits between the store and the result channel, so the next request is taken
// as soon as the last store read of a window has been issued.
module stereo_capture_ring_window_top import scrw_pkg::*; #(
    parameter int DEPTH       = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    scrw_in_if.sink               in_ch,
    scrw_out_if.source            out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CNT_W-1:0] capacity_reg;
    logic             reg_idx;
    logic             cfg_write;
    scrw_cmd_t        cmd;
    scrw_status_t     status;

    // Register decode.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[REG_IDX_LSB];
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (reg_idx == REG_CAPACITY) ? APB_DATA_W'(capacity_reg) : '0;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_write && (reg_idx == REG_CAPACITY))
        begin
            capacity_reg <= pwdata[CNT_W-1:0];
        end
    end

    scrw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_action (in_ch.action),
        .in_ready  (in_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    scrw_datapath #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .capacity      (capacity_reg),
        .left_sample   (in_ch.left_sample),
        .right_sample  (in_ch.right_sample),
        .window_frames (in_ch.window_frames),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .left_out      (out_ch.left_out),
        .right_out     (out_ch.right_out),
        .frame_count   (out_ch.frame_count),
        .last          (out_ch.last)
    );

endmodule

@@ tb/scrw_frame_checker.sv @@
`timescale 1ns / 1ps

// Watches the request, result and register channels of the capture ring. It keeps
// its own copy of the ring, predicts the frames of every extract request and
// compares each returned frame with the oldest prediction.
module scrw_frame_checker import scrw_pkg::*; #(
    parameter int DEPTH       = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    scrw_in_if                    in_mon,
    scrw_out_if                   out_mon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatch_total,
    output int                    frames_waiting,
    output int                    frames_checked
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic [CNT_W-1:0]              count;
        logic                          last;
    } stereo_frame_t;

    // Shadow of the ring and its pointers.
    logic signed [SAMPLE_BITS-1:0] left_ring [DEPTH];
    logic signed [SAMPLE_BITS-1:0] right_ring [DEPTH];
    logic [SLOT_W-1:0]             wr_slot;
    logic [CNT_W-1:0]              held_frames;
    logic [CNT_W-1:0]              ring_capacity;

    stereo_frame_t window_q[$];
    int            error_count = 0;
    int            checked_count = 0;

    // Applies one accepted request to the shadow ring and queues the frames
    // that an extract request returns.
    task automatic apply_ring_request(
        input logic                          act,
        input logic signed [SAMPLE_BITS-1:0] l_smp,
        input logic signed [SAMPLE_BITS-1:0] r_smp,
        input logic [CNT_W-1:0]              win
    );
        int unsigned   cap;
        int unsigned   avail;
        int unsigned   cnt;
        int unsigned   pos;
        int unsigned   nxt;
        int unsigned   idx;
        stereo_frame_t frm;

        cap = (32'(ring_capacity) > DEPTH) ? DEPTH : 32'(ring_capacity);
        // A ring with no capacity ignores everything.
        if (cap == 0)
            return;

        if (act == ACT_RECORD)
        begin
            left_ring[wr_slot]  = l_smp;
            right_ring[wr_slot] = r_smp;
            nxt = 32'(wr_slot) + 1;
            if (nxt >= cap)
                nxt = 0;
            wr_slot = SLOT_W'(nxt);
            if (32'(held_frames) < cap)
                held_frames = held_frames + CNT_W'(1);
            return;
        end

        // The window is clipped to what the ring holds and to the window limit.
        avail = (32'(held_frames) < cap) ? 32'(held_frames) : cap;
        cnt = 32'(win);
        if (cnt > avail)
            cnt = avail;
        if (cnt > 32'(WINDOW_MAX))
            cnt = 32'(WINDOW_MAX);
        if (cnt == 0)
            return;

        // Oldest frame of the window: behind the write slot once the ring has
        // wrapped, else counted from the start of the ring.
        if (32'(held_frames) >= cap)
            pos = (32'(wr_slot) + cap - cnt) % cap;
        else
            pos = 32'(held_frames) - cnt;

        for (idx = 0; idx < cnt; idx++)
        begin
            frm.left  = left_ring[SLOT_W'(pos % DEPTH)];
            frm.right = right_ring[SLOT_W'(pos % DEPTH)];
            frm.count = CNT_W'(cnt);
            frm.last  = (idx + 1 == cnt);
            window_q.push_back(frm);
            pos++;
            if (pos >= cap)
                pos = 0;
        end
    endtask

    // Compares one returned frame with the oldest prediction.
    task automatic check_frame();
        stereo_frame_t want;

        if (window_q.size() == 0)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("%0t: frame with no request behind it: left %0d right %0d %s %0d %s %0b",
                         $realtime, out_mon.left_out, out_mon.right_out,
                         "count", out_mon.frame_count, "last", out_mon.last);
            return;
        end

        want = window_q.pop_front();
        checked_count++;
        if (out_mon.left_out !== want.left || out_mon.right_out !== want.right ||
            out_mon.frame_count !== want.count || out_mon.last !== want.last)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
            begin
                $display("%0t: frame mismatch, expected left %0d right %0d count %0d last %0b",
                         $realtime, want.left, want.right, want.count, want.last);
                $display("%0t:                 actual   left %0d right %0d count %0d last %0b",
                         $realtime, out_mon.left_out, out_mon.right_out,
                         out_mon.frame_count, out_mon.last);
            end
        end
    endtask

    // Results of earlier requests are checked before the request of the same
    // edge is applied.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_slot       = '0;
            held_frames   = '0;
            ring_capacity = CAP_RESET;
            window_q.delete();
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
                check_frame();
            if (psel && penable && pwrite && pready && paddr[REG_IDX_LSB] == REG_CAPACITY)
                ring_capacity = pwdata[CNT_W-1:0];
            if (in_mon.valid && in_mon.ready)
                apply_ring_request(in_mon.action, in_mon.left_sample, in_mon.right_sample,
                                   in_mon.window_frames);
        end
        mismatch_total <= error_count;
        frames_waiting <= window_q.size();
        frames_checked <= checked_count;
    end

endmodule

@@ tb/tb_stereo_capture_ring_window_top.sv @@
`timescale 1ns / 1ps

module tb_stereo_capture_ring_window_top import scrw_pkg::*; ();

    localparam int DEPTH         = 64;
    localparam int SAMPLE_BITS   = 24;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 24;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'h7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'h800000;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_NEG1 = 24'hFFFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_ZERO = 24'h000000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    scrw_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
    scrw_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) frame_ch ();

    int fail_count;
    int frames_pending;
    int frames_seen;
    int send_idle_pct = 37;
    int recv_idle_pct = 51;
    int requests_sent = 0;
    int records_sent  = 0;
    int extracts_sent = 0;
    int holds_asked   = 0;
    int holds_done    = 0;

    stereo_capture_ring_window_top #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (req_ch),
        .out_ch  (frame_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    scrw_frame_checker #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_mon         (req_ch),
        .out_mon        (frame_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_total (fail_count),
        .frames_waiting (frames_pending),
        .frames_checked (frames_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("stereo_capture_ring_window_top test failed");
        $finish;
    end

    // Result sink: random stalls, and one long hold-off when asked for.
    initial
    begin
        int hold_left;

        frame_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_asked != holds_done)
            begin
                holds_done++;
                frame_ch.ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0)
                begin
                    @(posedge clk);
                    hold_left--;
                end
            end
            else
            begin
                frame_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(11))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_NEG1;
            3:       return SAMPLE_ZERO;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Short and random windows, with some empty, some full and some oversized ones.
    function automatic logic [CNT_W-1:0] pick_window();
        int unsigned roll;

        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 40)
            return CNT_W'($urandom_range(8, 1));
        if (roll < 75)
            return CNT_W'($urandom_range(64, 1));
        if (roll < 90)
            return WINDOW_MAX;
        return CNT_W'($urandom_range(127, 65));
    endfunction

    // Offers one request after an optional gap and waits until it is taken.
    task automatic drive_request(
        input logic                          act,
        input logic signed [SAMPLE_BITS-1:0] l_smp,
        input logic signed [SAMPLE_BITS-1:0] r_smp,
        input logic [CNT_W-1:0]              win
    );
        // Idle pattern: receiver-heavy, then sender-heavy, then none.
        if (requests_sent < 60)
        begin
            send_idle_pct = 37;
            recv_idle_pct = 51;
        end
        else if (requests_sent < 120)
        begin
            send_idle_pct = 51;
            recv_idle_pct = 37;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end

        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid         <= 1'b1;
        req_ch.action        <= act;
        req_ch.left_sample   <= l_smp;
        req_ch.right_sample  <= r_smp;
        req_ch.window_frames <= win;
        do
            @(posedge clk);
        while (!req_ch.ready);

        requests_sent++;
        if (act == ACT_RECORD)
            records_sent++;
        else
            extracts_sent++;
    endtask

    task automatic random_request(input int record_pct);
        if ($urandom_range(99) < record_pct)
            drive_request(ACT_RECORD, pick_sample(), pick_sample(), CNT_W'($urandom));
        else
            drive_request(ACT_EXTRACT, pick_sample(), pick_sample(), pick_window());
    endtask

    // Waits until every predicted frame has come back and the block is idle.
    task automatic settle();
        req_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (frames_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(REG_CAPACITY) << REG_IDX_LSB;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.action        <= ACT_RECORD;
        req_ch.left_sample   <= '0;
        req_ch.right_sample  <= '0;
        req_ch.window_frames <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-size ring: empty extracts, sample extremes and window clipping
        // while the ring is still filling.
        write_capacity(64);
        drive_request(ACT_EXTRACT, SAMPLE_ZERO, SAMPLE_ZERO, 7'd5);
        drive_request(ACT_RECORD, SAMPLE_MAX, SAMPLE_MIN, 7'd0);
        drive_request(ACT_RECORD, SAMPLE_MIN, SAMPLE_MAX, 7'd127);
        drive_request(ACT_RECORD, SAMPLE_ZERO, SAMPLE_NEG1, 7'd64);
        drive_request(ACT_RECORD, 24'h555555, 24'hAAAAAA, 7'd1);
        drive_request(ACT_EXTRACT, SAMPLE_MAX, SAMPLE_MIN, 7'd0);
        drive_request(ACT_EXTRACT, SAMPLE_ZERO, SAMPLE_ZERO, 7'd2);
        drive_request(ACT_EXTRACT, SAMPLE_ZERO, SAMPLE_ZERO, WINDOW_MAX);
        drive_request(ACT_EXTRACT, SAMPLE_NEG1, SAMPLE_NEG1, 7'd127);
        drive_request(ACT_RECORD, SAMPLE_NEG1, SAMPLE_ZERO, 7'd0);
        drive_request(ACT_EXTRACT, SAMPLE_ZERO, SAMPLE_ZERO, 7'd1);
        drive_request(ACT_EXTRACT, SAMPLE_ZERO, SAMPLE_ZERO, 7'd5);

        // Fill every slot of the ring before the capacity ever shrinks, so no
        // later window can reach a slot that was never written.
        while (records_sent < 72)
            random_request(80);

        // Small ring: wrapped reads and a pointer beyond the new capacity.
        settle();
        write_capacity(8);
        repeat (24) random_request(55);

        // Single-frame ring.
        settle();
        write_capacity(1);
        repeat (10) random_request(50);

        // Zero capacity: records are dropped and extracts return nothing.
        settle();
        write_capacity(0);
        repeat (8) random_request(50);

        // Capacity above the depth, with a long result stall under full windows.
        settle();
        write_capacity(127);
        holds_asked++;
        repeat (5) drive_request(ACT_EXTRACT, pick_sample(), pick_sample(), WINDOW_MAX);
        repeat (15) random_request(50);

        // Odd capacity.
        settle();
        write_capacity(37);
        repeat (25) random_request(55);

        settle();
        $display("Sent %0d requests (%0d records, %0d extracts)",
                 requests_sent, records_sent, extracts_sent);
        $display("at capacities 64, 8, 1, 0, 127, 37; compared %0d frames, %0d mismatches.",
                 frames_seen, fail_count);
        if (fail_count == 0 && frames_pending == 0)
            $display("stereo_capture_ring_window_top test passed");
        else
            $display("stereo_capture_ring_window_top test failed");
        $finish;
    end

endmodule
